// ===== design/square_falloff_height_mask_top_assert.svh =====
// ----------------------------------------------------------------------------
// Square falloff height mask: assertion macros
// Shared property shapes for the port checker, sampled on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef SQUARE_FALLOFF_HEIGHT_MASK_TOP_ASSERT_SVH
`define SQUARE_FALLOFF_HEIGHT_MASK_TOP_ASSERT_SVH

// Antecedent implies consequent in the same cycle
`define SFHM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sfhm: implication check failed");

// Condition must never hold
`define SFHM_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("sfhm: forbidden condition seen");

`endif

// ===== design/sfhm_pkg.sv =====
// ----------------------------------------------------------------------------
// sfhm_pkg
// Constants and types shared by the square falloff height mask and its checker.
// ----------------------------------------------------------------------------
package sfhm_pkg;

	localparam int unsigned MAX_DIM    = 4096;
	localparam int unsigned N_POW      = 15;   // largest exponent the 4-bit register holds
	localparam int unsigned DIV_STAGES = 8;    // two quotient bits per stage, 16 bits
	// entry + axis div + v + d + power + den + g div + output
	localparam int unsigned LATENCY    = 1 + DIV_STAGES + 1 + 1 + 2 * N_POW + 1 + DIV_STAGES + 1;

	// register indexes
	localparam logic [3:0] CFG_MAP_WIDTH  = 4'd0;
	localparam logic [3:0] CFG_MAP_HEIGHT = 4'd1;
	localparam logic [3:0] CFG_EXPONENT   = 4'd2;
	localparam logic [3:0] CFG_EDGE_SCALE = 4'd3;

	localparam logic [16:0] ONE_Q16 = 17'h10000;
	localparam logic [40:0] B_CAP   = 41'h4_0000_0000;

	// axis distance divider stage
	typedef struct packed {
		logic [7:0]  h;
		logic [12:0] xr;
		logic [12:0] xl;
		logic [15:0] xq;
		logic        xs;
		logic [12:0] yr;
		logic [12:0] yl;
		logic [15:0] yq;
		logic        ys;
	} axd_t;

	// v stage
	typedef struct packed {
		logic [7:0]  h;
		logic [16:0] v;
	} vst_t;

	// power chain stage
	typedef struct packed {
		logic [7:0]  h;
		logic [16:0] v;
		logic [20:0] d;
		logic [16:0] a;
		logic [34:0] b;
		logic [33:0] pa;
		logic [38:0] plo;
		logic [37:0] phi;
		logic        en;
	} pow_t;

	// falloff divider stage
	typedef struct packed {
		logic [7:0]  h;
		logic [35:0] rem;
		logic [35:0] den;
		logic [15:0] q;
		logic        zero;
		logic        full;
	} gdv_t;

endpackage

// ===== design/square_falloff_height_mask_top.sv =====
// ----------------------------------------------------------------------------
// square_falloff_height_mask_top
// Fades a height sample toward the raster edges along a square falloff curve.
// ----------------------------------------------------------------------------
// One pixel enters per clock: busy is always low and start may be held high
// every cycle. Each result appears on height_out with done high for one cycle,
// once its start beat has passed the whole pipeline; the depth comes from the
// two 16-bit restoring dividers (eight stages each) and the fifteen two-stage
// multiply steps of the exponent chain. Results cannot be held off. Width,
// height, exponent and scale are read live, so write them only while no pixel
// is in flight.
module square_falloff_height_mask_top
	import sfhm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  height_in,
	input  logic [11:0] col,
	input  logic [11:0] row,
	output logic        done,
	output logic [7:0]  height_out,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [12:0] map_width_q;
	logic [12:0] map_height_q;
	logic [3:0]  curve_exponent_q;
	logic [15:0] edge_scale_q;

	logic [LATENCY-1:0] vld_s;

	axd_t ad_s [0:DIV_STAGES];
	axd_t ad_n [1:DIV_STAGES];
	vst_t vs_s;
	pow_t pw_s [0:2*N_POW];
	pow_t pw_n [1:2*N_POW];
	gdv_t gd_s [0:DIV_STAGES];
	gdv_t gd_n [1:DIV_STAGES];
	logic [7:0] hout_q;

	logic [12:0] lw, lh, twx, twy, dfx, dfy;
	logic [16:0] vx, vy, vmax;
	logic [32:0] dprod;
	logic [35:0] den;
	logic [16:0] g;
	logic [24:0] pos, neg, diff;

	assign busy       = 1'b0;
	assign done       = vld_s[LATENCY-1];
	assign height_out = hout_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q      <= 13'd256;
			map_height_q     <= 13'd256;
			curve_exponent_q <= 4'd3;
			edge_scale_q     <= 16'd9011;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAP_WIDTH:  map_width_q      <= cfg_data[12:0];
				CFG_MAP_HEIGHT: map_height_q     <= cfg_data[12:0];
				CFG_EXPONENT:   curve_exponent_q <= cfg_data[3:0];
				CFG_EDGE_SCALE: edge_scale_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// valid bits travel alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[LATENCY-2:0], start};
		end
	end

	// one restoring step of the axis divider
	function automatic void ax_step(input logic [12:0] r, input logic [12:0] l,
			input logic [15:0] q, output logic [12:0] ro, output logic [15:0] qo);
		logic [13:0] r2;
		r2 = {r, 1'b0};
		if (r2 >= {1'b0, l}) begin
			ro = 13'(r2 - {1'b0, l});
			qo = {q[14:0], 1'b1};
		end else begin
			ro = r2[12:0];
			qo = {q[14:0], 1'b0};
		end
	endfunction

	// one restoring step of the falloff divider
	function automatic void g_step(input logic [35:0] r, input logic [35:0] dv,
			input logic [15:0] q, output logic [35:0] ro, output logic [15:0] qo);
		logic [36:0] r2;
		r2 = {r, 1'b0};
		if (r2 >= {1'b0, dv}) begin
			ro = 36'(r2 - {1'b0, dv});
			qo = {q[14:0], 1'b1};
		end else begin
			ro = r2[35:0];
			qo = {q[14:0], 1'b0};
		end
	endfunction

	// entry: clamp lengths, fold distance from center, flag saturation
	always_comb begin
		lw  = (map_width_q > 13'(MAX_DIM)) ? 13'(MAX_DIM) : map_width_q;
		lh  = (map_height_q > 13'(MAX_DIM)) ? 13'(MAX_DIM) : map_height_q;
		twx = {col, 1'b0};
		twy = {row, 1'b0};
		dfx = (twx >= lw) ? (twx - lw) : (lw - twx);
		dfy = (twy >= lh) ? (twy - lh) : (lh - twy);
	end

	// axis divider stages, two quotient bits each
	always_comb begin
		for (int j = 1; j <= DIV_STAGES; j++) begin
			ad_n[j] = ad_s[j-1];
			for (int k = 0; k < 2; k++) begin
				ax_step(ad_n[j].xr, ad_n[j].xl, ad_n[j].xq, ad_n[j].xr, ad_n[j].xq);
				ax_step(ad_n[j].yr, ad_n[j].yl, ad_n[j].yq, ad_n[j].yr, ad_n[j].yq);
			end
		end
	end

	// v = max of the axes, then d = s * (1 - v)
	always_comb begin
		vx    = ad_s[DIV_STAGES].xs ? ONE_Q16 : {1'b0, ad_s[DIV_STAGES].xq};
		vy    = ad_s[DIV_STAGES].ys ? ONE_Q16 : {1'b0, ad_s[DIV_STAGES].yq};
		vmax  = (vx > vy) ? vx : vy;
		dprod = edge_scale_q * (ONE_Q16 - vs_s.v);
	end

	// power chain: odd stages multiply, even stages shift and cap
	always_comb begin
		logic [56:0] bsum;
		for (int k = 0; k < N_POW; k++) begin
			pw_n[2*k+1]     = pw_s[2*k];
			pw_n[2*k+1].en  = (4'(k) < curve_exponent_q);
			pw_n[2*k+1].pa  = pw_s[2*k].a * pw_s[2*k].v;
			pw_n[2*k+1].plo = pw_s[2*k].b[17:0] * pw_s[2*k].d;
			pw_n[2*k+1].phi = pw_s[2*k].b[34:18] * pw_s[2*k].d;

			pw_n[2*k+2] = pw_s[2*k+1];
			bsum = {1'b0, pw_s[2*k+1].phi, 18'b0} + 57'(pw_s[2*k+1].plo);
			if (pw_s[2*k+1].en) begin
				pw_n[2*k+2].a = pw_s[2*k+1].pa[32:16];
				pw_n[2*k+2].b = (bsum[56:16] > B_CAP) ? B_CAP[34:0] : bsum[50:16];
			end
		end
	end

	// falloff divider stages
	always_comb begin
		den = 36'(pw_s[2*N_POW].a) + 36'(pw_s[2*N_POW].b);
		for (int j = 1; j <= DIV_STAGES; j++) begin
			gd_n[j] = gd_s[j-1];
			for (int k = 0; k < 2; k++) begin
				g_step(gd_n[j].rem, gd_n[j].den, gd_n[j].q, gd_n[j].rem, gd_n[j].q);
			end
		end
	end

	// output: h - 255*g, floored at zero
	always_comb begin
		g    = gd_s[DIV_STAGES].zero ? 17'd0 :
		       gd_s[DIV_STAGES].full ? ONE_Q16 : {1'b0, gd_s[DIV_STAGES].q};
		pos  = {1'b0, gd_s[DIV_STAGES].h, 16'b0};
		neg  = {g, 8'b0} - 25'(g);
		diff = pos - neg;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		ad_s[0].h  <= height_in;
		ad_s[0].xl <= lw;
		ad_s[0].xs <= (lw == 13'd0) || (dfx >= lw);
		ad_s[0].xr <= dfx;
		ad_s[0].xq <= '0;
		ad_s[0].yl <= lh;
		ad_s[0].ys <= (lh == 13'd0) || (dfy >= lh);
		ad_s[0].yr <= dfy;
		ad_s[0].yq <= '0;
		for (int j = 1; j <= DIV_STAGES; j++) begin
			ad_s[j] <= ad_n[j];
		end

		vs_s.h <= ad_s[DIV_STAGES].h;
		vs_s.v <= vmax;

		pw_s[0].h   <= vs_s.h;
		pw_s[0].v   <= vs_s.v;
		pw_s[0].d   <= dprod[32:12];
		pw_s[0].a   <= ONE_Q16;
		pw_s[0].b   <= 35'(ONE_Q16);
		pw_s[0].pa  <= '0;
		pw_s[0].plo <= '0;
		pw_s[0].phi <= '0;
		pw_s[0].en  <= 1'b0;
		for (int j = 1; j <= 2*N_POW; j++) begin
			pw_s[j] <= pw_n[j];
		end

		gd_s[0].h    <= pw_s[2*N_POW].h;
		gd_s[0].rem  <= 36'(pw_s[2*N_POW].a);
		gd_s[0].den  <= den;
		gd_s[0].q    <= '0;
		gd_s[0].zero <= (den == 36'd0);
		gd_s[0].full <= (pw_s[2*N_POW].b == 35'd0);
		for (int j = 1; j <= DIV_STAGES; j++) begin
			gd_s[j] <= gd_n[j];
		end

		hout_q <= (pos > neg) ? diff[23:16] : 8'd0;
	end

endmodule

// ===== design/sfhm_checker.sv =====
// ----------------------------------------------------------------------------
// sfhm_checker
// Port-level checks for the square falloff height mask, bound to the top.
// ----------------------------------------------------------------------------
`include "square_falloff_height_mask_top_assert.svh"

module sfhm_checker
	import sfhm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [7:0]  height_in,
	input logic        done,
	input logic [7:0]  height_out
);

	// pipeline never pushes back
	`SFHM_ASSERT_NEVER(a_never_busy, busy)

	// every result beat comes from a start beat that entered the whole pipeline
	`SFHM_ASSERT_IMP(a_done_has_start, done, $past(start, LATENCY))

	// the falloff only ever lowers the height
	`SFHM_ASSERT_IMP(a_out_not_above_in, done, height_out <= $past(height_in, LATENCY))

endmodule

bind square_falloff_height_mask_top sfhm_checker u_sfhm_checker (.*);

// ===== tb/tb_square_falloff_height_mask_top.sv =====
// ----------------------------------------------------------------------------
// Square falloff height mask testbench
// Drives pixel beats from a queue with random gaps, predicts each output
// height with an integer model of the falloff and compares in order.
// Registers are rewritten between phases once the pipeline has drained.
// ----------------------------------------------------------------------------
module tb_square_falloff_height_mask_top;
	import sfhm_pkg::*;

	typedef struct packed {
		logic [7:0]  h;
		logic [11:0] x;
		logic [11:0] y;
	} pixel_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [7:0]  height_in;
	logic [11:0] col;
	logic [11:0] row;
	logic        done;
	logic [7:0]  height_out;
	logic        cfg_we;
	logic [3:0]  cfg_index;
	logic [15:0] cfg_data;

	// model copy of the registers
	logic [12:0] w_reg;
	logic [12:0] h_reg;
	logic [3:0]  n_reg;
	logic [15:0] s_reg;

	pixel_t      pixel_q[$];
	logic [7:0]  height_exp_q[$];
	int          gap_left;
	int          n_err;
	int          idle_cycles;
	bit          timed_out;

	localparam int WATCHDOG = 20000;

	square_falloff_height_mask_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.height_in(height_in), .col(col), .row(row),
		.done(done), .height_out(height_out),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// distance from axis center in Q1.16, saturated at 1.0
	function automatic longint unsigned edge_dist(input longint unsigned pos,
			input longint unsigned len);
		longint unsigned l;
		longint unsigned diff;
		longint unsigned q;
		l = (len > MAX_DIM) ? MAX_DIM : len;
		if (l == 0) return 65536;
		diff = (2 * pos >= l) ? 2 * pos - l : l - 2 * pos;
		q = (diff << 16) / l;
		return (q > 65536) ? 65536 : q;
	endfunction

	function automatic logic [7:0] faded_height(input pixel_t p);
		longint unsigned vx, vy, v, d, a, b, g, pos, neg;
		vx = edge_dist(p.x, w_reg);
		vy = edge_dist(p.y, h_reg);
		v = (vx > vy) ? vx : vy;
		d = (longint'(s_reg) * (65536 - v)) >> 12;
		a = 65536;
		b = 65536;
		for (int k = 0; k < n_reg; k++) begin
			a = (a * v) >> 16;
			b = (b * d) >> 16;
			if (b > (64'd1 << 34)) b = 64'd1 << 34;
		end
		g = (a + b == 0) ? 0 : (a << 16) / (a + b);
		pos = longint'(p.h) << 16;
		neg = 255 * g;
		return (pos > neg) ? 8'((pos - neg) >> 16) : 8'd0;
	endfunction

	// driver: one beat per accepted item, random gap before each
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start    <= 1'b0;
			gap_left <= 0;
		end else begin
			if (start && !busy) begin
				height_exp_q.push_back(faded_height({height_in, col, row}));
			end
			if (start && !busy) begin
				if (gap_left == 0 && pixel_q.size() > 0) begin
					{height_in, col, row} <= pixel_q.pop_front();
					gap_left <= $urandom_range(0, 14);
				end else begin
					start <= 1'b0;
				end
			end else if (!start) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end else if (pixel_q.size() > 0) begin
					start <= 1'b1;
					{height_in, col, row} <= pixel_q.pop_front();
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
				end
			end
		end
	end

	// monitor: compare each result beat against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (height_exp_q.size() == 0) begin
				n_err = n_err + 1;
				if (n_err <= 10) $display("unexpected result beat height_out=%0d", height_out);
			end else begin
				logic [7:0] want;
				want = height_exp_q.pop_front();
				if (height_out !== want) begin
					n_err = n_err + 1;
					if (n_err <= 10)
						$display("height_out mismatch: expected %0d got %0d", want, height_out);
				end
			end
		end
	end

	// watchdog on cycles with no accepted beat and no result beat
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG && !timed_out) begin
			timed_out = 1'b1;
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pixel_q.size() > 0 || start || height_exp_q.size() > 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [3:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_MAP_WIDTH:  w_reg = val[12:0];
			CFG_MAP_HEIGHT: h_reg = val[12:0];
			CFG_EXPONENT:   n_reg = val[3:0];
			CFG_EDGE_SCALE: s_reg = val;
			default: ;
		endcase
	endtask

	task automatic set_all(input logic [15:0] wv, input logic [15:0] hv,
			input logic [15:0] nv, input logic [15:0] sv);
		write_reg(CFG_MAP_WIDTH, wv);
		write_reg(CFG_MAP_HEIGHT, hv);
		write_reg(CFG_EXPONENT, nv);
		write_reg(CFG_EDGE_SCALE, sv);
	endtask

	// random pixels, mostly inside the raster, some anywhere
	task automatic add_random(input int count);
		pixel_t p;
		for (int i = 0; i < count; i++) begin
			p.h = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 4) == 0 || w_reg == 0 || h_reg == 0) begin
				p.x = 12'($urandom);
				p.y = 12'($urandom);
			end else begin
				p.x = 12'($urandom_range(0, (w_reg > 4096 ? 4096 : w_reg) - 1));
				p.y = 12'($urandom_range(0, (h_reg > 4096 ? 4096 : h_reg) - 1));
			end
			pixel_q.push_back(p);
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		height_in = '0;
		col       = '0;
		row       = '0;
		n_err     = 0;
		w_reg = 13'd256;
		h_reg = 13'd256;
		n_reg = 4'd3;
		s_reg = 16'd9011;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset settings, corners, center, out of raster
		pixel_q.push_back({8'd255, 12'd0, 12'd0});
		pixel_q.push_back({8'd255, 12'd128, 12'd128});
		pixel_q.push_back({8'd0, 12'd128, 12'd128});
		pixel_q.push_back({8'd200, 12'd255, 12'd255});
		pixel_q.push_back({8'd255, 12'd4095, 12'd4095});
		pixel_q.push_back({8'd170, 12'd300, 12'd10});
		pixel_q.push_back({8'd85, 12'd64, 12'd192});
		pixel_q.push_back({8'd255, 12'd2730, 12'd1365});
		wait_drained();

		// exponent zero, zero scale, oversize raster
		set_all(16'd4096, 16'd8191, 16'd0, 16'd0);
		pixel_q.push_back({8'd255, 12'd2048, 12'd2048});
		pixel_q.push_back({8'd127, 12'd100, 12'd4000});
		wait_drained();
		write_reg(CFG_EXPONENT, 16'd15);
		pixel_q.push_back({8'd255, 12'd2048, 12'd2048});
		pixel_q.push_back({8'd255, 12'd1000, 12'd3000});
		wait_drained();

		// zero width, height of one, max scale, ignored index
		set_all(16'd0, 16'd1, 16'd1, 16'd65535);
		write_reg(4'd9, 16'hFFFF);
		pixel_q.push_back({8'd255, 12'd0, 12'd0});
		pixel_q.push_back({8'd1, 12'd5, 12'd0});
		wait_drained();

		// random phases with various settings
		set_all(16'd256, 16'd256, 16'd3, 16'd9011);
		add_random(90);
		wait_drained();
		set_all(16'd1, 16'd4096, 16'd8, 16'd65535);
		add_random(70);
		wait_drained();
		set_all(16'd37, 16'd13, 16'd1, 16'd1);
		add_random(70);
		wait_drained();
		set_all(16'd4095, 16'd2, 16'd15, 16'd4096);
		add_random(70);
		wait_drained();
		set_all(16'($urandom_range(1, 8191)), 16'($urandom_range(1, 8191)),
			16'($urandom_range(0, 15)), 16'($urandom));
		add_random(70);
		wait_drained();
		set_all(16'd640, 16'd480, 16'd5, 16'd20000);
		add_random(70);
		wait_drained();

		if (n_err == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/sfhm_pkg.sv
design/square_falloff_height_mask_top.sv
design/sfhm_checker.sv
tb/tb_square_falloff_height_mask_top.sv
